### rtl/core/gstm_pkg.sv
`default_nettype none

package gstm_pkg;

    // default bounds of the image buffer
    localparam int DEF_MAX_WIDTH  = 128;
    localparam int DEF_MAX_HEIGHT = 128;

    // configuration port
    localparam int CFG_W = 8;
    localparam int IDX_W = 2;

    localparam logic [IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [IDX_W-1:0] REG_BRIGHT_LIMIT = 2'd2;

    localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 8'd128;
    localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 8'd128;
    localparam logic [CFG_W-1:0] BRIGHT_LIMIT_RST = 8'd200;

    localparam int MIN_WIDTH  = 3;
    localparam int MIN_HEIGHT = 1;

    // mark counter, saturating
    localparam int              COUNT_W   = 14;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 14'h3FFF;

    // queue depths
    localparam int CMDQ_DEPTH = 4;
    localparam int RESQ_DEPTH = 2;
    localparam int RESQ_CNT_W = $clog2(RESQ_DEPTH + 1);

    // gradient sign codes as stored in the mask
    typedef logic [1:0] sign_t;
    localparam sign_t SIGN_FLAT = 2'd0;
    localparam sign_t SIGN_RISE = 2'd1;
    localparam sign_t SIGN_FALL = 2'd2;

    typedef enum logic [1:0] {
        OP_SKIP,
        OP_LEARN,
        OP_UPDATE
    } cmd_op_t;

    // classified pixel handed from the front to the back
    typedef struct packed {
        cmd_op_t op;
        sign_t   code;
        logic    dark;
        logic    zero_en;
        logic    frame_start;
        logic    emit;
    } cmd_t;

endpackage

`default_nettype wire

### rtl/core/gstm_fifo.sv
`default_nettype none

module gstm_fifo #(
    parameter int DW    = 8,
    parameter int DEPTH = 4
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         push,
    input  wire logic [DW-1:0]                din,
    input  wire logic                         pop,
    output logic      [DW-1:0]                dout,
    output logic                              full,
    output logic                              empty,
    output logic      [$clog2(DEPTH+1)-1:0]   count
);

    localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);

    logic [DW-1:0]   store_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNTW-1:0] count_reg, count_next;
    logic            do_push, do_pop;

    assign full    = (count_reg == CNTW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign count   = count_reg;
    assign dout    = store_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNTW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNTW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            store_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

`default_nettype wire

### rtl/core/gstm_front.sv
`default_nettype none

module gstm_front #(
    parameter int MAX_WIDTH  = gstm_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = gstm_pkg::DEF_MAX_HEIGHT
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_write,
    input  wire logic [gstm_pkg::IDX_W-1:0]     cfg_index,
    input  wire logic [gstm_pkg::CFG_W-1:0]     cfg_data,
    input  wire logic                           accept,
    input  wire logic [7:0]                     pixel,
    input  wire logic                           learn,
    output gstm_pkg::cmd_t                      cmd,
    output logic [((MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1)-1:0] cmd_row,
    output logic [$clog2(MAX_WIDTH)-1:0]        cmd_col
);

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int RW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int MW  = (CW > RW) ? CW : RW;
    localparam int XW  = ((MW > gstm_pkg::CFG_W) ? MW : gstm_pkg::CFG_W) + 2;

    logic [gstm_pkg::CFG_W-1:0] width_reg, height_reg, limit_reg;
    logic [CW-1:0]              col_reg, col_next;
    logic [RW-1:0]              row_reg, row_next;
    logic [7:0]                 near_reg, far_reg;

    logic [XW-1:0] wreg_x, hreg_x, wlim, hlim;
    logic [XW-1:0] row_step, col_inc, row_inc;
    logic          wrap_pre, last_col, last_row;
    logic [CW-1:0] c;
    logic [RW-1:0] r;

    // clamp the programmed frame size to what the mask can hold
    always_comb
    begin
        wreg_x = XW'(width_reg);
        hreg_x = XW'(height_reg);
        priority if (wreg_x < XW'(gstm_pkg::MIN_WIDTH))
            wlim = XW'(gstm_pkg::MIN_WIDTH);
        else if (wreg_x > XW'(MAX_WIDTH))
            wlim = XW'(MAX_WIDTH);
        else
            wlim = wreg_x;
        priority if (hreg_x < XW'(gstm_pkg::MIN_HEIGHT))
            hlim = XW'(gstm_pkg::MIN_HEIGHT);
        else if (hreg_x > XW'(MAX_HEIGHT))
            hlim = XW'(MAX_HEIGHT);
        else
            hlim = hreg_x;
    end

    // position of the arriving pixel, wrapping stale counts after a resize
    always_comb
    begin
        wrap_pre = (XW'(col_reg) >= wlim);
        c        = wrap_pre ? '0 : col_reg;
        row_step = XW'(row_reg) + (wrap_pre ? XW'(1) : XW'(0));
        r        = (row_step >= hlim) ? '0 : row_step[RW-1:0];
        col_inc  = XW'(c) + XW'(1);
        row_inc  = XW'(r) + XW'(1);
        last_col = (col_inc == wlim);
        last_row = (row_inc == hlim);
        col_next = last_col ? '0 : col_inc[CW-1:0];
        if (last_col)
            row_next = last_row ? '0 : row_inc[RW-1:0];
        else
            row_next = r;
    end

    // classify the pixel pair: sign of the step and brightness
    always_comb
    begin
        cmd = '0;
        if (pixel > far_reg)
            cmd.code = gstm_pkg::SIGN_RISE;
        else if (pixel < far_reg)
            cmd.code = gstm_pkg::SIGN_FALL;
        else
            cmd.code = gstm_pkg::SIGN_FLAT;
        cmd.dark        = (pixel < limit_reg) && (far_reg < limit_reg);
        if (c >= CW'(2))
            cmd.op = learn ? gstm_pkg::OP_LEARN : gstm_pkg::OP_UPDATE;
        else
            cmd.op = gstm_pkg::OP_SKIP;
        cmd.zero_en     = learn && ((col_inc + XW'(1)) >= wlim);
        cmd.frame_start = (c == '0) && (r == '0);
        cmd.emit        = last_col && last_row && !learn;
    end

    assign cmd_row = r;
    assign cmd_col = c;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= gstm_pkg::FRAME_WIDTH_RST;
            height_reg <= gstm_pkg::FRAME_HEIGHT_RST;
            limit_reg  <= gstm_pkg::BRIGHT_LIMIT_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                gstm_pkg::REG_FRAME_WIDTH:  width_reg  <= cfg_data;
                gstm_pkg::REG_FRAME_HEIGHT: height_reg <= cfg_data;
                gstm_pkg::REG_BRIGHT_LIMIT: limit_reg  <= cfg_data;
                default:                    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            near_reg <= '0;
            far_reg  <= '0;
        end
        else if (accept)
        begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            far_reg  <= near_reg;
            near_reg <= pixel;
        end
    end

endmodule

`default_nettype wire

### rtl/core/gstm_back.sv
`default_nettype none

module gstm_back #(
    parameter int MAX_WIDTH  = gstm_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = gstm_pkg::DEF_MAX_HEIGHT
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cq_empty,
    input  wire gstm_pkg::cmd_t                     cmd,
    input  wire logic [((MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1)-1:0] cmd_row,
    input  wire logic [$clog2(MAX_WIDTH)-1:0]       cmd_col,
    output logic                                    cq_pop,
    input  wire logic [gstm_pkg::RESQ_CNT_W-1:0]    rq_count,
    output logic                                    rq_push,
    output logic [gstm_pkg::COUNT_W-1:0]            rq_data
);

    localparam int CW         = $clog2(MAX_WIDTH);
    localparam int RW         = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int BW         = CW - 1;
    localparam int BANK_DEPTH = MAX_HEIGHT * (2 ** BW);
    localparam int AW         = $clog2(BANK_DEPTH);
    localparam int OW         = gstm_pkg::RESQ_CNT_W + 1;

    // column bit 1 picks the bank, so column x and x-2 never share one
    function automatic logic [AW-1:0] bank_addr(input logic [RW-1:0] row,
                                                input logic [CW-1:0] col);
        logic [BW-1:0] cb;
        cb = BW'((col >> 2) << 1) | BW'(col[0]);
        return AW'({row, cb});
    endfunction

    logic [CW-1:0]  mark_col;
    logic           mark_bank, zero_bank;
    logic [AW-1:0]  mark_addr, zero_addr;
    logic [OW-1:0]  occupied;

    gstm_pkg::cmd_t b_cmd_reg;
    logic           b_valid_reg;
    logic           b_mark_bank_reg, b_zero_bank_reg;
    logic [AW-1:0]  b_mark_addr_reg, b_zero_addr_reg;

    logic [gstm_pkg::COUNT_W-1:0] cnt_reg, cnt_next, cnt_base;

    gstm_pkg::sign_t mark;
    logic            inc, clr, mark_we, zero_we;
    gstm_pkg::sign_t mark_data;

    logic            wr_en   [2];
    logic [AW-1:0]   wr_addr [2];
    gstm_pkg::sign_t wr_data [2];
    gstm_pkg::sign_t rd_data [2];

    // pop only while a count finished by the word in flight still finds room
    assign occupied = OW'(rq_count) + OW'(b_valid_reg && b_cmd_reg.emit);
    assign cq_pop   = !cq_empty && (occupied < OW'(gstm_pkg::RESQ_DEPTH));

    assign mark_col  = cmd_col - CW'(2);
    assign mark_bank = mark_col[1];
    assign zero_bank = cmd_col[1];
    assign mark_addr = bank_addr(cmd_row, mark_col);
    assign zero_addr = bank_addr(cmd_row, cmd_col);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b_valid_reg <= 1'b0;
        else
            b_valid_reg <= cq_pop;
    end

    always_ff @(posedge clk)
    begin
        if (cq_pop)
        begin
            b_cmd_reg       <= cmd;
            b_mark_bank_reg <= mark_bank;
            b_zero_bank_reg <= zero_bank;
            b_mark_addr_reg <= mark_addr;
            b_zero_addr_reg <= zero_addr;
        end
    end

    // resolve the mark read in the cycle before
    always_comb
    begin
        mark      = rd_data[b_mark_bank_reg];
        inc       = 1'b0;
        clr       = 1'b0;
        mark_we   = 1'b0;
        mark_data = gstm_pkg::SIGN_FLAT;
        unique case (b_cmd_reg.op)
            gstm_pkg::OP_LEARN:
            begin
                mark_we   = b_valid_reg;
                mark_data = b_cmd_reg.code;
            end
            gstm_pkg::OP_UPDATE:
            begin
                if (b_cmd_reg.dark)
                begin
                    if (mark == gstm_pkg::SIGN_RISE || mark == gstm_pkg::SIGN_FALL)
                    begin
                        if (mark == b_cmd_reg.code)
                            inc = 1'b1;
                        else
                            clr = 1'b1;
                    end
                end
                else if (mark != gstm_pkg::SIGN_FLAT)
                begin
                    inc = 1'b1;
                end
                mark_we = b_valid_reg && clr;
            end
            default:
            begin
            end
        endcase
        zero_we  = b_valid_reg && b_cmd_reg.zero_en;
        cnt_base = b_cmd_reg.frame_start ? '0 : cnt_reg;
        cnt_next = (inc && cnt_base != gstm_pkg::COUNT_MAX)
                 ? cnt_base + gstm_pkg::COUNT_W'(1) : cnt_base;
    end

    assign rq_push = b_valid_reg && b_cmd_reg.emit;
    assign rq_data = cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else if (b_valid_reg)
            cnt_reg <= cnt_next;
    end

    for (genvar gi = 0; gi < 2; gi++)
    begin : g_bank
        logic [1:0]      mem [BANK_DEPTH];
        gstm_pkg::sign_t rd_reg;
        logic            hit_mark;

        assign hit_mark    = mark_we && (b_mark_bank_reg == 1'(gi));
        assign wr_en[gi]   = hit_mark || (zero_we && (b_zero_bank_reg == 1'(gi)));
        assign wr_addr[gi] = hit_mark ? b_mark_addr_reg : b_zero_addr_reg;
        assign wr_data[gi] = hit_mark ? mark_data : gstm_pkg::SIGN_FLAT;
        assign rd_data[gi] = rd_reg;

        always_ff @(posedge clk)
        begin
            if (wr_en[gi])
                mem[wr_addr[gi]] <= wr_data[gi];
            if (cq_pop && cmd.op == gstm_pkg::OP_UPDATE && mark_bank == 1'(gi))
                rd_reg <= mem[mark_addr];
        end
    end

endmodule

`default_nettype wire

### rtl/core/gradient_sign_mask_tracker.sv
`default_nettype none

// Gradient sign mask tracker. Push one 8-bit pixel word per clock in raster
// order with learn held for the frame. A learn frame stores, per position, the
// sign of (pixel two columns right - pixel): flat, rising or falling; the last
// two columns of each row store flat. An update frame clears a stored sign when
// both pixels are below bright_limit and the sign no longer holds, and after
// its last pixel emits one points_left word: the marks still set in the frame,
// saturating at 16383. Configuration (frame_width, frame_height, bright_limit)
// is written through cfg_write/cfg_index/cfg_data while no pixel is in flight;
// sizes out of range are clamped to 3..MAX_WIDTH and 1..MAX_HEIGHT. Sustained
// rate is one pixel per clock while neither queue holds the flow. A pixel
// passes the front classifier, waits in a four-word command queue, then
// passes the back: mask read, then compare, write-back and count. The mask
// is split into two banks on column bit 1, each with one read and one write
// port, so the sign write and the end-of-row flat write of a learn pixel land
// in the same clock. Results wait in a two-word queue; the back holds a pixel
// while the waiting counts and one in flight leave no room there, and a full
// command queue raises full. The mask has no reset: run a learn frame before
// the first update frame.
module gradient_sign_mask_tracker #(
    parameter int MAX_WIDTH  = gstm_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = gstm_pkg::DEF_MAX_HEIGHT
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_write,
    input  wire logic [gstm_pkg::IDX_W-1:0]     cfg_index,
    input  wire logic [gstm_pkg::CFG_W-1:0]     cfg_data,
    input  wire logic [7:0]                     pixel,
    input  wire logic                           learn,
    input  wire logic                           push,
    output logic                                full,
    output logic [gstm_pkg::COUNT_W-1:0]        points_left,
    output logic                                empty,
    input  wire logic                           pop
);

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int RW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int CQW = $bits(gstm_pkg::cmd_t) + RW + CW;

    logic                          accept;
    gstm_pkg::cmd_t                front_cmd, back_cmd;
    logic [RW-1:0]                 front_row, back_row;
    logic [CW-1:0]                 front_col, back_col;
    logic [CQW-1:0]                cq_din, cq_dout;
    logic                          cq_empty, cq_pop;
    logic                          rq_push;
    logic [gstm_pkg::COUNT_W-1:0]  rq_data;
    logic [gstm_pkg::RESQ_CNT_W-1:0] rq_count;

    // take a pixel word whenever the command queue has room
    assign accept = push && !full;

    gstm_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .pixel     (pixel),
        .learn     (learn),
        .cmd       (front_cmd),
        .cmd_row   (front_row),
        .cmd_col   (front_col)
    );

    assign cq_din = {front_cmd, front_row, front_col};
    assign {back_cmd, back_row, back_col} = cq_dout;

    // decouple classification from the mask read-modify-write
    gstm_fifo #(
        .DW    (CQW),
        .DEPTH (gstm_pkg::CMDQ_DEPTH)
    ) u_cmd_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (accept),
        .din   (cq_din),
        .pop   (cq_pop),
        .dout  (cq_dout),
        .full  (full),
        .empty (cq_empty),
        .count ()
    );

    gstm_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cq_empty (cq_empty),
        .cmd      (back_cmd),
        .cmd_row  (back_row),
        .cmd_col  (back_col),
        .cq_pop   (cq_pop),
        .rq_count (rq_count),
        .rq_push  (rq_push),
        .rq_data  (rq_data)
    );

    // hold finished counts until the consumer pops them
    gstm_fifo #(
        .DW    (gstm_pkg::COUNT_W),
        .DEPTH (gstm_pkg::RESQ_DEPTH)
    ) u_res_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (rq_push),
        .din   (rq_data),
        .pop   (pop),
        .dout  (points_left),
        .full  (),
        .empty (empty),
        .count (rq_count)
    );

endmodule

`default_nettype wire

### rtl/core/gstm_checker.sv
`default_nettype none

module gstm_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          push,
    input wire logic                          full,
    input wire logic                          pop,
    input wire logic                          empty,
    input wire logic [gstm_pkg::COUNT_W-1:0]  points_left
);

    // the command queue only fills from pushed words
    a_full_needs_push: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(full) |-> $past(push))
        else $error("full rose without a pushed word");

    // with no result waiting the back always drains the command queue
    a_full_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (full && empty) |=> !full)
        else $error("command queue stuck while result queue is empty");

    // a waiting result holds until popped
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(points_left)))
        else $error("waiting result changed or vanished");

endmodule

bind gradient_sign_mask_tracker gstm_checker u_checker (.*);

`default_nettype wire

### tb/gradient_sign_mask_tracker_tb.sv
`timescale 1ns / 100ps

module gradient_sign_mask_tracker_tb;
    import gstm_pkg::*;

    localparam int MASK_STRIDE  = DEF_MAX_WIDTH;
    localparam int MASK_DEPTH   = DEF_MAX_WIDTH * DEF_MAX_HEIGHT;
    // command queue plus the back end, with margin
    localparam int DRAIN_CYCLES = 12;
    localparam int LONG_HOLD    = 400;
    localparam int RUN_LIMIT_NS = 5_000_000;

    // learn frame 4x2, then two update frames: one keeps both marks (one
    // by a bright pair), one breaks both marks on dark pairs
    localparam logic [7:0] DIRECTED_PIX [24] = '{
        8'd0,   8'd10, 8'd255, 8'd10, 8'd50,  8'd60, 8'd40,  8'd60,
        8'd5,   8'd10, 8'd100, 8'd10, 8'd250, 8'd60, 8'd255, 8'd60,
        8'd100, 8'd0,  8'd50,  8'd0,  8'd50,  8'd0,  8'd60,  8'd0
    };

    typedef struct packed {
        logic [7:0] px;
        logic       lrn;
    } pixel_word_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_write = 1'b0;
    logic [IDX_W-1:0]   cfg_index = '0;
    logic [CFG_W-1:0]   cfg_data = '0;
    logic [7:0]         pixel = '0;
    logic               learn = 1'b0;
    logic               push = 1'b0;
    logic               full;
    logic [COUNT_W-1:0] points_left;
    logic               empty;
    logic               pop = 1'b0;

    // stimulus side: words waiting for the driver, and the generator's own
    // view of the raster position and of which mask entries hold a sign
    pixel_word_t        pixel_backlog[$];
    logic [CFG_W-1:0]   gen_cfg [3] = '{FRAME_WIDTH_RST, FRAME_HEIGHT_RST, BRIGHT_LIMIT_RST};
    bit                 learned [MASK_DEPTH];
    int                 gen_col = 0;
    int                 gen_row = 0;
    int                 gen_results = 0;
    bit                 frame_learn = 1'b1;

    // tracker state, advanced on every accepted pixel word
    logic [CFG_W-1:0]   model_cfg [3] = '{FRAME_WIDTH_RST, FRAME_HEIGHT_RST, BRIGHT_LIMIT_RST};
    sign_t              sign_marks [MASK_DEPTH];
    logic [7:0]         prev_px [2] = '{8'd0, 8'd0};
    int                 pos_col = 0;
    int                 pos_row = 0;
    logic [COUNT_W-1:0] mark_total = '0;
    logic [COUNT_W-1:0] expected_counts[$];

    int                 sender_idle_pct = 0;
    int                 receiver_idle_pct = 0;
    bit                 stall_arm = 1'b0;
    int                 hold_left = 0;
    int                 errors = 0;

    gradient_sign_mask_tracker DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .pixel      (pixel),
        .learn      (learn),
        .push       (push),
        .full       (full),
        .points_left(points_left),
        .empty      (empty),
        .pop        (pop)
    );

    always #5 clk = ~clk;

    // Clamp the raw register values the same way the block does.
    function automatic int clamp_width(input logic [CFG_W-1:0] v);
        if (v < MIN_WIDTH)
            return MIN_WIDTH;
        if (v > DEF_MAX_WIDTH)
            return DEF_MAX_WIDTH;
        return int'(v);
    endfunction

    function automatic int clamp_height(input logic [CFG_W-1:0] v);
        if (v < MIN_HEIGHT)
            return MIN_HEIGHT;
        if (v > DEF_MAX_HEIGHT)
            return DEF_MAX_HEIGHT;
        return int'(v);
    endfunction

    // Advance the tracker by one pixel word; queue a count when the word
    // closes an update frame.
    task automatic track_pixel(input logic [7:0] px, input logic lrn);
        int         w;
        int         h;
        int         col;
        int         row;
        int         idx;
        logic [7:0] left;
        logic [7:0] limit;
        sign_t      m;
        w = clamp_width(model_cfg[REG_FRAME_WIDTH]);
        h = clamp_height(model_cfg[REG_FRAME_HEIGHT]);
        limit = model_cfg[REG_BRIGHT_LIMIT];
        // bounds may have shrunk since the last word: wrap the position
        if (pos_col >= w)
        begin
            pos_col = 0;
            pos_row++;
        end
        if (pos_row >= h)
            pos_row = 0;
        col = pos_col;
        row = pos_row;
        if (col == 0 && row == 0)
            mark_total = '0;
        left = prev_px[1];
        if (col >= 2)
        begin
            idx = row * MASK_STRIDE + col - 2;
            if (lrn)
            begin
                sign_marks[idx] = (px > left) ? SIGN_RISE : ((px < left) ? SIGN_FALL : SIGN_FLAT);
            end
            else
            begin
                m = sign_marks[idx];
                if (px < limit && left < limit)
                begin
                    // dark pair: keep the mark only if its sign still holds
                    if (m == SIGN_RISE)
                    begin
                        if (px > left)
                        begin
                            if (mark_total < COUNT_MAX)
                                mark_total++;
                        end
                        else
                            sign_marks[idx] = SIGN_FLAT;
                    end
                    else if (m == SIGN_FALL)
                    begin
                        if (px < left)
                        begin
                            if (mark_total < COUNT_MAX)
                                mark_total++;
                        end
                        else
                            sign_marks[idx] = SIGN_FLAT;
                    end
                end
                else if (m != SIGN_FLAT)
                begin
                    // bright pair: the mark stays as it is
                    if (mark_total < COUNT_MAX)
                        mark_total++;
                end
            end
        end
        // last two columns of a learn row store flat
        if (lrn && col + 2 >= w)
            sign_marks[row * MASK_STRIDE + col] = SIGN_FLAT;
        prev_px[1] = prev_px[0];
        prev_px[0] = px;
        if (col + 1 == w && row + 1 == h && !lrn)
            expected_counts.push_back(mark_total);
        pos_col = col + 1;
        if (pos_col >= w)
        begin
            pos_col = 0;
            pos_row = row + 1;
            if (pos_row >= h)
                pos_row = 0;
        end
    endtask

    // Queue one pixel word. lrn_sel below zero lets the frame choice decide,
    // with a rare flip of learn inside the frame. Never let an update read a
    // mask entry that no learn word has written: force learn there.
    task automatic add_item(input logic [7:0] px, input int lrn_sel);
        int          w;
        int          h;
        bit          lrn;
        pixel_word_t word;
        w = clamp_width(gen_cfg[REG_FRAME_WIDTH]);
        h = clamp_height(gen_cfg[REG_FRAME_HEIGHT]);
        if (gen_col >= w)
        begin
            gen_col = 0;
            gen_row++;
        end
        if (gen_row >= h)
            gen_row = 0;
        if (gen_col == 0 && gen_row == 0)
            frame_learn = ($urandom_range(99) < 35);
        if (lrn_sel >= 0)
            lrn = (lrn_sel != 0);
        else
            lrn = ($urandom_range(99) < 5) ? !frame_learn : frame_learn;
        if (gen_col >= 2 && !learned[gen_row * MASK_STRIDE + gen_col - 2])
            lrn = 1'b1;
        if (lrn && gen_col >= 2)
            learned[gen_row * MASK_STRIDE + gen_col - 2] = 1'b1;
        if (lrn && gen_col + 2 >= w)
            learned[gen_row * MASK_STRIDE + gen_col] = 1'b1;
        if (!lrn && gen_col + 1 == w && gen_row + 1 == h)
            gen_results++;
        word.px = px;
        word.lrn = lrn;
        pixel_backlog.push_back(word);
        gen_col++;
        if (gen_col >= w)
        begin
            gen_col = 0;
            gen_row++;
            if (gen_row >= h)
                gen_row = 0;
        end
    endtask

    // Mix extremes, values around the brightness limit and near-equal
    // values (flat signs) with plain random pixels.
    function automatic logic [7:0] rand_pixel();
        case ($urandom_range(3))
            0: return $urandom_range(1) ? 8'd255 : 8'd0;
            1: return 8'(gen_cfg[REG_BRIGHT_LIMIT] + $urandom_range(2) - 1);
            2: return 8'(8'd100 + $urandom_range(3));
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic fill_random(input int n_items, input int min_results);
        int added;
        int first;
        added = 0;
        first = gen_results;
        while (added < n_items || gen_results - first < min_results)
        begin
            add_item(rand_pixel(), -1);
            added++;
        end
    endtask

    // Hold the sender until the block has drained: no word left to send,
    // no count outstanding, and time for result-free words to clear the pipe.
    task automatic wait_idle();
        while (pixel_backlog.size() != 0 || push || expected_counts.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        model_cfg[idx] <= val;
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    // Drain, write all three registers, then pick the idling mode:
    // 0 none, 1 sender idle, 2 receiver stalling, 3 both.
    task automatic set_config(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h,
                              input logic [CFG_W-1:0] b, input int mode);
        wait_idle();
        write_reg(REG_FRAME_WIDTH, w);
        write_reg(REG_FRAME_HEIGHT, h);
        write_reg(REG_BRIGHT_LIMIT, b);
        gen_cfg[REG_FRAME_WIDTH] = w;
        gen_cfg[REG_FRAME_HEIGHT] = h;
        gen_cfg[REG_BRIGHT_LIMIT] = b;
        @(negedge clk);
        sender_idle_pct = (mode == 1) ? 83 : ((mode == 3) ? 35 : 0);
        receiver_idle_pct = (mode == 2) ? 83 : ((mode == 3) ? 35 : 0);
    endtask

    // Driver: advance the tracker on each accepted word, then offer the
    // next one unless the sender idles. Hold a word while full is high.
    always @(posedge clk)
    begin : drive_pixels
        pixel_word_t word;
        if (!rst_n)
            push <= 1'b0;
        else
        begin
            if (push && !full)
                track_pixel(pixel, learn);
            if (!push || !full)
            begin
                if (pixel_backlog.size() != 0 && $urandom_range(99) >= sender_idle_pct)
                begin
                    word = pixel_backlog.pop_front();
                    pixel <= word.px;
                    learn <= word.lrn;
                    push <= 1'b1;
                end
                else
                    push <= 1'b0;
            end
        end
    end

    // Long receiver hold-off, started by a one-cycle arm from the sequence.
    always @(posedge clk)
    begin
        if (!rst_n)
            hold_left <= 0;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
        else if (stall_arm)
            hold_left <= LONG_HOLD;
    end

    // Monitor: check each popped count against the oldest expectation.
    always @(posedge clk)
    begin : check_counts
        logic [COUNT_W-1:0] want;
        if (!rst_n)
            pop <= 1'b0;
        else
        begin
            if (pop && !empty)
            begin
                if (expected_counts.size() == 0)
                begin
                    $display("%0t: points_left %0d popped with no count expected",
                             $time, points_left);
                    errors++;
                end
                else
                begin
                    want = expected_counts.pop_front();
                    if (points_left !== want)
                    begin
                        $display("%0t: points_left expected %0d, actual %0d",
                                 $time, want, points_left);
                        errors++;
                    end
                end
            end
            pop <= (hold_left == 0) && ($urandom_range(99) >= receiver_idle_pct);
        end
    end

    initial
    begin
        #(RUN_LIMIT_NS);
        $display("gradient_sign_mask_tracker_tb NOT OK");
        $finish;
    end

    initial
    begin
        logic [CFG_W-1:0] w_sel;
        logic [CFG_W-1:0] h_sel;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: learn a 4x2 frame, then keep marks, then break them
        set_config(8'd4, 8'd2, 8'd200, 0);
        for (int i = 0; i < 24; i++)
            add_item(DIRECTED_PIX[i], (i < 8) ? 1 : 0);

        // width and height below range clamp to 3x1; a pair counts as dark unless it holds a 255
        set_config(8'd0, 8'd0, 8'd255, 1);
        fill_random(30, 4);

        // width above range clamps to 128; limit 0 makes every pair bright
        set_config(8'd255, 8'd1, 8'd0, 2);
        fill_random(130, 0);

        set_config(8'd5, 8'd3, 8'd128, 3);
        fill_random(60, 2);

        // tiny frames end every third word, each update frame with a count: stall the receiver for a
        // long stretch so the result queue and then the command queue fill up
        set_config(8'd3, 8'd1, 8'd200, 0);
        stall_arm = 1'b1;
        @(negedge clk);
        stall_arm = 1'b0;
        fill_random(40, 10);

        // height above range clamps to 128 rows; the frame runs on past here
        set_config(8'd3, 8'd255, 8'd100, 1);
        fill_random(40, 0);

        // random small bounds; phases end mid-frame, so bounds change mid-frame
        for (int p = 0; p < 6; p++)
        begin
            w_sel = CFG_W'(($urandom_range(7) == 0) ? $urandom_range(2) : $urandom_range(3, 9));
            h_sel = CFG_W'($urandom_range(4));
            set_config(w_sel, h_sel, CFG_W'($urandom), p % 4);
            fill_random(15, 1);
        end

        wait_idle();
        if (errors == 0)
            $display("gradient_sign_mask_tracker_tb OK");
        else
            $display("gradient_sign_mask_tracker_tb NOT OK");
        $finish;
    end

endmodule

### filelist.f
rtl/core/gstm_pkg.sv
rtl/core/gstm_fifo.sv
rtl/core/gstm_front.sv
rtl/core/gstm_back.sv
rtl/core/gradient_sign_mask_tracker.sv
rtl/core/gstm_checker.sv
tb/gradient_sign_mask_tracker_tb.sv
